/* rtl/core/dpfd_pkg.sv */
// Shared types and constants for the pulse frame decoder.
`default_nettype none

package dpfd_pkg;

  // Frame geometry: one start pulse followed by 40 data pulses
  localparam int unsigned DATA_BITS    = 40;
  localparam int unsigned FRAME_PULSES = DATA_BITS + 1;
  localparam int unsigned COUNT_W      = 6;

  // Input command codes
  localparam logic CMD_START = 1'b0;
  localparam logic CMD_PULSE = 1'b1;

  // Sensor variants
  typedef enum logic [1:0] {
    SENSOR_DHT11 = 2'd0,
    SENSOR_DHT12 = 2'd1,
    SENSOR_DHT21 = 2'd2,
    SENSOR_DHT22 = 2'd3
  } sensor_t;

  // Result status codes
  typedef enum logic [1:0] {
    STATUS_OK         = 2'd0,
    STATUS_CSUM_ERR   = 2'd1,
    STATUS_START_FAIL = 2'd2
  } status_t;

  // Configuration register indexes (byte address = 4 * index)
  typedef enum logic [1:0] {
    REG_SENSOR_TYPE   = 2'd0,
    REG_BIT_THRESHOLD = 2'd1,
    REG_START_MIN     = 2'd2
  } reg_idx_t;

  // Reset values
  localparam logic [1:0]  SENSOR_TYPE_RST   = 2'd3;
  localparam logic [7:0]  BIT_THRESHOLD_RST = 8'd40;
  localparam logic [7:0]  START_MIN_RST     = 8'd40;
  localparam logic [15:0] TEMP_RST          = 16'd250;
  localparam logic [15:0] HUM_RST           = 16'd500;

  // Completed frame handed from the collector to the converter
  typedef struct packed {
    logic                 start_ok;
    logic [DATA_BITS-1:0] bits;
  } frame_t;

endpackage

`default_nettype wire

/* rtl/core/dpfd_collect.sv */
// Pulse collector: counts pulses, slices data bits and registers completed frames.
`default_nettype none

module dpfd_collect
  import dpfd_pkg::*;
(
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         in_valid,
  output logic              in_ready,
  input  wire logic         in_cmd,
  input  wire logic [15:0]  in_pulse_width_us,
  input  wire logic [7:0]   bit_threshold_us,
  input  wire logic [7:0]   start_min_us,
  output logic              frame_valid,
  output frame_t            frame,
  input  wire logic         frame_take
);

  logic [COUNT_W-1:0]   pulse_count_r, pulse_count_nxt;
  logic                 start_ok_r, start_ok_nxt;
  logic [DATA_BITS-1:0] bits_r, bits_nxt;
  logic                 done_valid_r, done_valid_nxt;
  frame_t               done_r, done_nxt;
  logic                 accept;

  // Room for a new transaction whenever the completed-frame slot is free or draining
  assign in_ready = !done_valid_r || frame_take;
  assign accept   = in_valid && in_ready;

  // Frame state update
  always_comb begin
    pulse_count_nxt = pulse_count_r;
    start_ok_nxt    = start_ok_r;
    bits_nxt        = bits_r;
    done_valid_nxt  = done_valid_r && !frame_take;
    done_nxt        = done_r;
    if (accept) begin
      if (in_cmd == CMD_START) begin
        pulse_count_nxt = '0;
        start_ok_nxt    = 1'b0;
        bits_nxt        = '0;
      end else if (pulse_count_r < COUNT_W'(FRAME_PULSES)) begin
        if (pulse_count_r == '0) begin
          start_ok_nxt = (in_pulse_width_us >= {8'd0, start_min_us});
        end else begin
          bits_nxt = {bits_r[DATA_BITS-2:0], (in_pulse_width_us > {8'd0, bit_threshold_us})};
        end
        pulse_count_nxt = pulse_count_r + COUNT_W'(1);
        // Last pulse of the frame: hand the frame on
        if (pulse_count_nxt == COUNT_W'(FRAME_PULSES)) begin
          done_valid_nxt    = 1'b1;
          done_nxt.start_ok = start_ok_nxt;
          done_nxt.bits     = bits_nxt;
        end
      end
    end
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pulse_count_r <= COUNT_W'(FRAME_PULSES);
      start_ok_r    <= 1'b0;
      bits_r        <= '0;
      done_valid_r  <= 1'b0;
    end else begin
      pulse_count_r <= pulse_count_nxt;
      start_ok_r    <= start_ok_nxt;
      bits_r        <= bits_nxt;
      done_valid_r  <= done_valid_nxt;
    end
  end

  // Completed frame payload
  always_ff @(posedge clk) begin
    done_r <= done_nxt;
  end

  assign frame_valid = done_valid_r;
  assign frame       = done_r;

  // Count never runs past the end of a frame
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    pulse_count_r <= COUNT_W'(FRAME_PULSES))
    else $error("pulse count beyond frame length");

  // A pending frame holds until the converter takes it
  a_frame_hold: assert property (@(posedge clk) disable iff (!rst_n)
    done_valid_r && !frame_take |=> done_valid_r && $stable(done_r))
    else $error("pending frame lost or changed");

  // A frame is handed on only when its last pulse was just accepted
  a_frame_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(done_valid_r) |-> pulse_count_r == COUNT_W'(FRAME_PULSES))
    else $error("frame handed on without a full pulse count");

endmodule

`default_nettype wire

/* rtl/core/dpfd_convert.sv */
// Frame checker and converter: checksum, sensor-specific scaling, result register.
`default_nettype none

module dpfd_convert
  import dpfd_pkg::*;
(
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         frame_valid,
  input  wire frame_t       frame,
  output logic              frame_take,
  input  wire logic [1:0]   sensor_type,
  output logic              out_valid,
  input  wire logic         out_ready,
  output logic [1:0]        out_status,
  output logic [15:0]       out_temperature_tenths,
  output logic [15:0]       out_humidity_tenths
);

  logic           out_valid_r, out_valid_nxt;
  status_t        status_r, status_nxt;
  logic [15:0]    good_temp_r, good_temp_nxt;
  logic [15:0]    good_hum_r, good_hum_nxt;
  logic [7:0]     b0, b1, b2, b3, b4;
  logic [9:0]     byte_sum;
  logic [15:0]    b0x10, b2x10;
  logic [15:0]    temp_cv, hum_cv;
  logic           load;

  // Result slot is free or being emptied this cycle
  assign frame_take = !out_valid_r || out_ready;
  assign load       = frame_take && frame_valid;

  // Byte split, first received byte is the most significant
  assign b0 = frame.bits[39:32];
  assign b1 = frame.bits[31:24];
  assign b2 = frame.bits[23:16];
  assign b3 = frame.bits[15:8];
  assign b4 = frame.bits[7:0];

  assign byte_sum = {2'd0, b0} + {2'd0, b1} + {2'd0, b2} + {2'd0, b3};

  // Times ten as shift-and-add
  assign b0x10 = {5'd0, b0, 3'd0} + {7'd0, b0, 1'd0};
  assign b2x10 = {5'd0, b2, 3'd0} + {7'd0, b2, 1'd0};

  // Sensor-specific conversion to tenths
  always_comb begin
    temp_cv = '0;
    hum_cv  = b0x10 + {8'd0, b1};
    case (sensor_t'(sensor_type))
      SENSOR_DHT11: begin
        temp_cv = b2x10;
        if (b3[7]) begin
          temp_cv = 16'd0 - 16'd10 - b2x10;
        end
        temp_cv = temp_cv + {12'd0, b3[3:0]};
      end
      SENSOR_DHT12: begin
        temp_cv = b2x10 + {12'd0, b3[3:0]};
        if (b2[7]) begin
          temp_cv = 16'd0 - temp_cv;
        end
      end
      default: begin
        temp_cv = {1'b0, b2[6:0], b3};
        if (b2[7]) begin
          temp_cv = 16'd0 - temp_cv;
        end
        hum_cv = {b0, b1};
      end
    endcase
  end

  // Status and stored readings
  always_comb begin
    out_valid_nxt = out_valid_r && !out_ready;
    status_nxt    = status_r;
    good_temp_nxt = good_temp_r;
    good_hum_nxt  = good_hum_r;
    if (load) begin
      out_valid_nxt = 1'b1;
      if (!frame.start_ok) begin
        status_nxt = STATUS_START_FAIL;
      end else if (byte_sum[7:0] != b4) begin
        status_nxt = STATUS_CSUM_ERR;
      end else begin
        status_nxt    = STATUS_OK;
        good_temp_nxt = temp_cv;
        good_hum_nxt  = hum_cv;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      good_temp_r <= TEMP_RST;
      good_hum_r  <= HUM_RST;
    end else begin
      out_valid_r <= out_valid_nxt;
      good_temp_r <= good_temp_nxt;
      good_hum_r  <= good_hum_nxt;
    end
  end

  always_ff @(posedge clk) begin
    status_r <= status_nxt;
  end

  assign out_valid              = out_valid_r;
  assign out_status             = status_r;
  assign out_temperature_tenths = good_temp_r;
  assign out_humidity_tenths    = good_hum_r;

  // Readings move only when a frame is loaded
  a_readings_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !load |=> $stable(good_temp_r) && $stable(good_hum_r))
    else $error("readings changed without a frame");

  // A loaded frame always produces a result next cycle
  a_load_result: assert property (@(posedge clk) disable iff (!rst_n)
    load |=> out_valid_r)
    else $error("frame loaded but no result");

  // A rejected frame leaves the readings untouched
  a_reject_keeps: assert property (@(posedge clk) disable iff (!rst_n)
    load && !frame.start_ok |=> $stable(good_temp_r) && $stable(good_hum_r))
    else $error("rejected frame changed readings");

endmodule

`default_nettype wire

/* rtl/core/dht_pulse_frame_decoder_unit.sv */
// Top level of the single-wire sensor pulse frame decoder.
//
//   Channel   Direction  Handshake          Payload
//   in_       input      in_valid/in_ready  in_cmd, in_pulse_width_us
//   out_      output     out_valid/out_ready out_status, out_temperature_tenths,
//                                           out_humidity_tenths
//   APB       config     psel/penable/pready paddr, pwdata, prdata
//
// One transaction per cycle on the input while in_ready is high. The collector
// counts pulses and slices bits, the completed frame is registered, and the
// checksum and conversion land in the result register, so the 41st pulse goes
// through the frame register, then the result register. A stalled result holds
// in_ready low only once a second completed frame is waiting behind it. rst_n
// is synchronous; after reset no frame is open until a start command arrives.
`default_nettype none

module dht_pulse_frame_decoder_unit
  import dpfd_pkg::*;
(
  input  wire logic         clk,
  input  wire logic         rst_n,
  // Input channel
  input  wire logic         in_valid,
  output logic              in_ready,
  input  wire logic         in_cmd,
  input  wire logic [15:0]  in_pulse_width_us,
  // Result channel
  output logic              out_valid,
  input  wire logic         out_ready,
  output logic [1:0]        out_status,
  output logic signed [15:0] out_temperature_tenths,
  output logic [15:0]       out_humidity_tenths,
  // Configuration port
  input  wire logic         psel,
  input  wire logic         penable,
  input  wire logic         pwrite,
  input  wire logic [3:0]   paddr,
  input  wire logic [31:0]  pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  logic [1:0]   sensor_type_r;
  logic [7:0]   bit_threshold_r;
  logic [7:0]   start_min_r;
  logic         cfg_wr;
  reg_idx_t     cfg_idx;
  logic         frame_valid;
  frame_t       frame;
  logic         frame_take;
  logic [15:0]  temp_u;

  // Configuration registers
  assign pready  = 1'b1;
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign cfg_idx = reg_idx_t'(paddr[3:2]);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sensor_type_r   <= SENSOR_TYPE_RST;
      bit_threshold_r <= BIT_THRESHOLD_RST;
      start_min_r     <= START_MIN_RST;
    end else if (cfg_wr) begin
      case (cfg_idx)
        REG_SENSOR_TYPE:   sensor_type_r   <= pwdata[1:0];
        REG_BIT_THRESHOLD: bit_threshold_r <= pwdata[7:0];
        REG_START_MIN:     start_min_r     <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  // Register readback
  always_comb begin
    case (cfg_idx)
      REG_SENSOR_TYPE:   prdata = {30'd0, sensor_type_r};
      REG_BIT_THRESHOLD: prdata = {24'd0, bit_threshold_r};
      REG_START_MIN:     prdata = {24'd0, start_min_r};
      default:           prdata = '0;
    endcase
  end

  dpfd_collect u_collect (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_cmd            (in_cmd),
    .in_pulse_width_us (in_pulse_width_us),
    .bit_threshold_us  (bit_threshold_r),
    .start_min_us      (start_min_r),
    .frame_valid       (frame_valid),
    .frame             (frame),
    .frame_take        (frame_take)
  );

  dpfd_convert u_convert (
    .clk                    (clk),
    .rst_n                  (rst_n),
    .frame_valid            (frame_valid),
    .frame                  (frame),
    .frame_take             (frame_take),
    .sensor_type            (sensor_type_r),
    .out_valid              (out_valid),
    .out_ready              (out_ready),
    .out_status             (out_status),
    .out_temperature_tenths (temp_u),
    .out_humidity_tenths    (out_humidity_tenths)
  );

  assign out_temperature_tenths = signed'(temp_u);

endmodule

`default_nettype wire
